// ===== sv/sprite_animation_sequencer_core_defines.svh =====
// Assertion macros shared by the sprite animation sequencer RTL.
`ifndef SPRITE_ANIMATION_SEQUENCER_CORE_DEFINES_SVH
`define SPRITE_ANIMATION_SEQUENCER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising edge outside reset.
`define SAS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SAS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SAS_ASSERT_IMP(lbl, ante, cons, msg)
`define SAS_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ===== sv/sas_pkg.sv =====
// Package with the types, codes and defaults of the sprite animation sequencer.
package sas_pkg;

  // Default sizes of the frame table.
  localparam int SAS_MAX_FRAMES = 256;
  localparam int SAS_CELL_BITS  = 12;

  // Request codes carried by req_type.
  localparam logic [2:0] REQ_TICK  = 3'd0;
  localparam logic [2:0] REQ_PLAY  = 3'd1;
  localparam logic [2:0] REQ_PAUSE = 3'd2;
  localparam logic [2:0] REQ_SET   = 3'd3;
  localparam logic [2:0] REQ_LOAD  = 3'd4;

  // Configuration register indexes.
  localparam logic [7:0] CFG_FRAME_WIDTH   = 8'd0;
  localparam logic [7:0] CFG_FRAME_HEIGHT  = 8'd1;
  localparam logic [7:0] CFG_SHEET_COLUMNS = 8'd2;
  localparam logic [7:0] CFG_FRAME_COUNT   = 8'd3;
  localparam logic [7:0] CFG_INTERVAL_MS   = 8'd4;
  localparam logic [7:0] CFG_LOOPING       = 8'd5;
  localparam logic [7:0] CFG_COOLDOWN_MS   = 8'd6;
  localparam logic [7:0] CFG_START_PLAYING = 8'd7;

  // Animation states as reported on state_code.
  typedef enum logic [1:0] {
    ANIM_PLAY     = 2'd0,
    ANIM_PAUSE    = 2'd1,
    ANIM_ENDED    = 2'd2,
    ANIM_COOLDOWN = 2'd3
  } anim_state_t;

endpackage

// ===== sv/sas_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module sas_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/sas_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
module sas_div #(
  parameter int DW = 32,
  parameter int VW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic [DW-1:0] quot,
  output logic [VW-1:0] rem
);

  localparam int CW = $clog2(DW + 1);

  logic [CW-1:0] cnt;
  logic [VW-1:0] dvs;
  logic [VW:0]   trial;
  logic          ge;

  // The partial remainder stays below the divisor, so the trial fits in VW+1 bits.
  assign trial = {rem, quot[DW-1]};
  assign ge    = trial >= {1'b0, dvs};
  assign busy  = cnt != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt  <= CW'(DW);
      quot <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      cnt  <= cnt - 1'b1;
      quot <= {quot[DW-2:0], ge};
      rem  <= ge ? VW'(trial - {1'b0, dvs}) : trial[VW-1:0];
    end
  end

endmodule

// ===== sv/sprite_animation_sequencer_core.sv =====
// Top level of the sprite animation sequencer: control, frame table and dividers.
//
// Usage: requests arrive as words on the in channel (valid/ready) and every
// request gives exactly one result word on the out channel (valid/ready).
// A tick reports the sheet pixel origin of the current frame cell and then
// advances the animation; play, pause, set-frame and table-load requests
// change the state and report it with a zero origin. Register writes come on
// the cfg channel, which is always ready; they are to be made while the
// block idles, which the block itself does not enforce.
// Throughput: one request at a time. A tick passes through a table read,
// the time divider with the cell divider running beside it, a wait until
// both dividers are done, an advance step and an output step; the next
// request is taken once the block is back in idle. Other requests pass
// through an execute step and the output step.
// The output register holds a finished word; if the receiver stalls, the
// block takes the next request, works on it, and waits with that result
// until the register is free.
// Reset is synchronous: registers return to their defaults, the animation
// pauses at frame 0, and the frame table holds no defined content until
// it is loaded.
module sprite_animation_sequencer_core
  import sas_pkg::*;
#(
  parameter int MAX_FRAMES = SAS_MAX_FRAMES,
  parameter int CELL_BITS  = SAS_CELL_BITS
) (
  input  logic        clk,
  input  logic        rst,
  // Request channel.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  req_type,
  input  logic [31:0] now_ms,
  input  logic [15:0] delta_ms,
  input  logic [7:0]  frame_pos,
  input  logic [11:0] cell_number,
  // Result channel.
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  state_code,
  output logic [7:0]  current_pos,
  output logic [19:0] src_x,
  output logic [19:0] src_y,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);

`include "sprite_animation_sequencer_core_defines.svh"

  // Address width of the table and a wider index width for range checks.
  localparam int AW  = $clog2(MAX_FRAMES);
  localparam int IW  = ((AW > 8) ? AW : 8) + 1;
  // Width that holds both a loaded cell and a stored cell.
  localparam int CXW = (CELL_BITS > 12) ? CELL_BITS : 12;
  // Product width of the row pixel multiplier.
  localparam int PYW = ((11 + CELL_BITS) > 20) ? (11 + CELL_BITS) : 20;
  // Usable sequence length.
  localparam logic [8:0] COUNT_LIMIT = 9'((MAX_FRAMES < 256) ? MAX_FRAMES : 256);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RD,
    S_DIV,
    S_ADV,
    S_FIN
  } seq_state_t;

  seq_state_t  st;
  anim_state_t anim_state;

  // Configuration registers.
  logic [10:0] frame_width;
  logic [10:0] frame_height;
  logic [8:0]  sheet_columns;
  logic [8:0]  frame_count;
  logic [15:0] interval_ms;
  logic        looping;
  logic [15:0] cooldown_ms;
  logic        start_playing;

  // Animation state.
  logic [7:0]  frame_index;
  logic        frame_was_set;
  logic [31:0] time_accum;
  logic [31:0] cooldown_end;
  logic        untouched;

  // Latched request.
  logic [2:0]  req_r;
  logic [31:0] now_r;
  logic [7:0]  pos_r;
  logic [11:0] cellin_r;
  logic        rd_ok;
  logic [19:0] sx;
  logic [19:0] sy;

  // Table and arithmetic.
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [CELL_BITS-1:0] ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [CELL_BITS-1:0] ram_rdata;
  logic [CELL_BITS-1:0] rd_cell;
  logic [IW-1:0]        fi_ext;
  logic [IW-1:0]        pos_ext;
  logic [CXW-1:0]       cellin_ext;
  logic [8:0]           cols;
  logic [15:0]          iv;
  logic [8:0]           total;
  logic [7:0]           last_pos;
  logic [32:0]          acc_sum;
  logic [31:0]          acc_sat;
  logic [32:0]          idx_sum;
  logic                 div_start;
  logic                 acc_busy;
  logic                 cell_busy;
  logic [31:0]          acc_q;
  logic [15:0]          acc_r;
  logic [CELL_BITS-1:0] cell_q;
  logic [8:0]           cell_r;
  logic [19:0]          prod_x;
  logic [PYW-1:0]       prod_y;

  assign in_ready  = st == S_IDLE;
  assign cfg_ready = 1'b1;

  // Zero divisors and a zero count act as one; the count is clamped to the table size and at most 256.
  assign cols     = (sheet_columns == '0) ? 9'd1 : sheet_columns;
  assign iv       = (interval_ms == '0) ? 16'd1 : interval_ms;
  assign total    = (frame_count == '0) ? 9'd1 :
                    ((frame_count > COUNT_LIMIT) ? COUNT_LIMIT : frame_count);
  assign last_pos = 8'(total - 9'd1);

  assign acc_sum = {1'b0, time_accum} + 33'(delta_ms);
  assign acc_sat = acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
  assign idx_sum = 33'(frame_index) + 33'(acc_q);

  // Table addressing; an index outside the table reads as cell zero.
  assign fi_ext     = IW'(frame_index);
  assign pos_ext    = IW'(pos_r);
  assign cellin_ext = CXW'(cellin_r);
  assign ram_raddr  = fi_ext[AW-1:0];
  assign ram_waddr  = pos_ext[AW-1:0];
  assign ram_wdata  = cellin_ext[CELL_BITS-1:0];
  assign ram_we     = (st == S_EXEC) && (req_r == REQ_LOAD) && (pos_ext < IW'(MAX_FRAMES));
  assign rd_cell    = rd_ok ? ram_rdata : '0;

  assign div_start = st == S_RD;

  assign prod_x = 20'(frame_width) * 20'(cell_r);
  assign prod_y = PYW'(frame_height) * PYW'(cell_q);

  sas_ram #(
    .WIDTH (CELL_BITS),
    .DEPTH (MAX_FRAMES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Cell number split into sheet column and row.
  sas_div #(
    .DW (CELL_BITS),
    .VW (9)
  ) u_cell_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rd_cell),
    .divisor  (cols),
    .busy     (cell_busy),
    .quot     (cell_q),
    .rem      (cell_r)
  );

  // Accumulated time divided by the frame interval gives the frame step.
  sas_div #(
    .DW (32),
    .VW (16)
  ) u_acc_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (time_accum),
    .divisor  (iv),
    .busy     (acc_busy),
    .quot     (acc_q),
    .rem      (acc_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st            <= S_IDLE;
      anim_state    <= ANIM_PAUSE;
      frame_index   <= '0;
      frame_was_set <= 1'b0;
      time_accum    <= '0;
      cooldown_end  <= '0;
      untouched     <= 1'b1;
      out_valid     <= 1'b0;
      frame_width   <= 11'd32;
      frame_height  <= 11'd32;
      sheet_columns <= 9'd1;
      frame_count   <= 9'd1;
      interval_ms   <= 16'd100;
      looping       <= 1'b0;
      cooldown_ms   <= '0;
      start_playing <= 1'b0;
    end else begin
      // In S_FIN the finished word decides the output register itself.
      if (out_valid && out_ready && st != S_FIN) begin
        out_valid <= 1'b0;
      end

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_FRAME_WIDTH:   frame_width   <= cfg_data[10:0];
          CFG_FRAME_HEIGHT:  frame_height  <= cfg_data[10:0];
          CFG_SHEET_COLUMNS: sheet_columns <= cfg_data[8:0];
          CFG_FRAME_COUNT:   frame_count   <= cfg_data[8:0];
          CFG_INTERVAL_MS:   interval_ms   <= cfg_data;
          CFG_LOOPING:       looping       <= cfg_data[0];
          CFG_COOLDOWN_MS:   cooldown_ms   <= cfg_data;
          CFG_START_PLAYING: begin
            start_playing <= cfg_data[0];
            // Before the first request the start mode also sets the state.
            if (untouched) begin
              anim_state <= cfg_data[0] ? ANIM_PLAY : ANIM_PAUSE;
            end
          end
          default: ;
        endcase
      end

      unique case (st)
        S_IDLE: begin
          if (in_valid) begin
            req_r     <= req_type;
            now_r     <= now_ms;
            pos_r     <= frame_pos;
            cellin_r  <= cell_number;
            rd_ok     <= fi_ext < IW'(MAX_FRAMES);
            untouched <= 1'b0;
            if (req_type == REQ_TICK) begin
              if (anim_state == ANIM_PLAY) begin
                time_accum <= acc_sat;
              end
              st <= S_RD;
            end else begin
              st <= S_EXEC;
            end
          end
        end

        S_EXEC: begin
          sx <= '0;
          sy <= '0;
          unique case (req_r)
            REQ_PLAY: begin
              if (anim_state == ANIM_ENDED || anim_state == ANIM_COOLDOWN) begin
                if (!frame_was_set) begin
                  frame_index <= '0;
                end
                frame_was_set <= 1'b0;
              end
              anim_state <= ANIM_PLAY;
            end
            REQ_PAUSE: begin
              if (anim_state == ANIM_PLAY || anim_state == ANIM_COOLDOWN) begin
                anim_state <= ANIM_PAUSE;
              end
            end
            REQ_SET: begin
              frame_index <= ({1'b0, pos_r} < total) ? pos_r : last_pos;
              if (anim_state == ANIM_ENDED || anim_state == ANIM_COOLDOWN) begin
                frame_was_set <= 1'b1;
              end
            end
            default: ;
          endcase
          st <= S_FIN;
        end

        S_RD: begin
          st <= S_DIV;
        end

        S_DIV: begin
          if (!acc_busy && !cell_busy) begin
            st <= S_ADV;
          end
        end

        S_ADV: begin
          sx <= prod_x;
          sy <= prod_y[19:0];
          unique case (anim_state)
            ANIM_PLAY: begin
              if (acc_q != '0) begin
                time_accum <= '0;
                if (idx_sum >= 33'(total)) begin
                  // Stepped past the last frame: hold it and end or cool down.
                  frame_index <= last_pos;
                  if (looping) begin
                    cooldown_end <= now_r + 32'(cooldown_ms);
                    anim_state   <= ANIM_COOLDOWN;
                  end else begin
                    anim_state <= ANIM_ENDED;
                  end
                end else begin
                  frame_index <= idx_sum[7:0];
                end
              end
            end
            ANIM_COOLDOWN: begin
              if (now_r >= cooldown_end) begin
                if (!frame_was_set) begin
                  frame_index <= '0;
                end
                frame_was_set <= 1'b0;
                anim_state    <= ANIM_PLAY;
              end
            end
            ANIM_PAUSE, ANIM_ENDED: ;
          endcase
          st <= S_FIN;
        end

        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            state_code  <= anim_state;
            current_pos <= frame_index;
            src_x       <= sx;
            src_y       <= sy;
            st          <= S_IDLE;
          end
        end
      endcase
    end
  end

  `SAS_ASSERT_IMP(a_div_done_at_adv, st == S_ADV, !acc_busy && !cell_busy,
                  "advance step taken while a divider is still busy")
  `SAS_ASSERT_NXT(a_div_stays, st == S_DIV, st == S_DIV || st == S_ADV,
                  "divide wait left toward an unexpected step")
  `SAS_ASSERT_NXT(a_fin_delivers, st == S_FIN && (!out_valid || out_ready),
                  out_valid && st == S_IDLE,
                  "finished result not placed in the output register")
  `SAS_ASSERT_NXT(a_cooldown_holds, st == S_IDLE && anim_state == ANIM_COOLDOWN,
                  anim_state == ANIM_COOLDOWN,
                  "cooldown state changed without a request")

endmodule
